// File: rtl/core/crq_pkg.sv
`default_nettype none

package crq_pkg;

    // Number of commands the queue can hold.
    localparam int QUEUE_DEPTH = 5;
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0]  SEQ_LIMIT   = 8'd254;
    localparam logic [7:0]  SENDS_MAX   = 8'd255;
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    localparam logic [15:0] RETRY_RESET     = 16'd500;
    localparam logic [7:0]  MAX_SENDS_RESET = 8'd20;
    localparam logic [7:0]  HOPS_RESET      = 8'd5;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_HOST = 2'd1,
        CMD_RX   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        HK_NONE = 3'd0,
        HK_HELP = 3'd1,
        HK_WARN = 3'd2,
        HK_MARK = 3'd3,
        HK_PING = 3'd4
    } host_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RETRY     = 3'd0,
        CFG_MAX_SENDS = 3'd1,
        CFG_MESH      = 3'd2,
        CFG_DEVICE    = 3'd3,
        CFG_HOPS      = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  usb_kind;
        logic [7:0]  dest_id;
        logic [31:0] lat_bits;
        logic [31:0] lng_bits;
        logic        rx_pong;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  dest;
        logic [31:0] lat;
        logic [31:0] lng;
    } entry_t;

    typedef struct packed {
        logic   avail;
        entry_t entry;
    } head_t;

    typedef struct packed {
        logic [15:0] retry_interval;
        logic [7:0]  max_sends;
        logic [7:0]  mesh_id;
        logic [7:0]  device_id;
        logic [7:0]  hop_limit;
    } cfg_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_mesh;
        logic [7:0]  tx_source;
        logic [7:0]  tx_dest;
        logic [7:0]  tx_hops;
        logic [1:0]  tx_kind;
        logic [7:0]  tx_sequence;
        logic [31:0] tx_lat;
        logic [31:0] tx_lng;
        logic        busy_res;
    } tx_t;

    typedef struct packed {
        tx_t        tx;
        logic [2:0] queue_level;
        logic       dropped;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/crq_if.sv
`default_nettype none

interface crq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [2:0]  usb_kind;
    logic [7:0]  dest_id;
    logic [31:0] lat_bits;
    logic [31:0] lng_bits;
    logic        rx_pong;

    modport source (output valid, command, usb_kind, dest_id, lat_bits, lng_bits, rx_pong,
                    input ready);
    modport sink (input valid, command, usb_kind, dest_id, lat_bits, lng_bits, rx_pong,
                  output ready);
endinterface

interface crq_out_if;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [7:0]  tx_mesh;
    logic [7:0]  tx_source;
    logic [7:0]  tx_dest;
    logic [7:0]  tx_hops;
    logic [1:0]  tx_kind;
    logic [7:0]  tx_sequence;
    logic [31:0] tx_lat;
    logic [31:0] tx_lng;
    logic        busy_res;
    logic [2:0]  queue_level;
    logic        dropped;

    modport source (output valid, tx_valid, tx_mesh, tx_source, tx_dest, tx_hops, tx_kind,
                    tx_sequence, tx_lat, tx_lng, busy_res, queue_level, dropped,
                    input ready);
    modport sink (input valid, tx_valid, tx_mesh, tx_source, tx_dest, tx_hops, tx_kind,
                  tx_sequence, tx_lat, tx_lng, busy_res, queue_level, dropped,
                  output ready);
endinterface

interface crq_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [crq_pkg::CFG_IDX_W-1:0]  index;
    logic [crq_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/crq_fifo.sv
`default_nettype none

// Command FIFO. An entry pushed into an empty queue is forwarded to the head
// in the same cycle so that it can be taken by the same item.
module crq_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire crq_pkg::item_t item,
    input  wire logic           pop,
    output crq_pkg::head_t      head,
    output logic [2:0]          level,
    output logic                dropped
);

    crq_pkg::entry_t mem [crq_pkg::QUEUE_DEPTH];

    logic [crq_pkg::IDX_W-1:0] head_reg, head_next;
    logic [crq_pkg::IDX_W-1:0] tail_reg, tail_next;
    logic [crq_pkg::CNT_W-1:0] count_reg, count_next;

    logic            push_req;
    logic            full;
    logic            push;
    crq_pkg::entry_t in_entry;

    function automatic logic [crq_pkg::IDX_W-1:0] next_slot(
        input logic [crq_pkg::IDX_W-1:0] i
    );
        logic [crq_pkg::IDX_W-1:0] r;
        if (i == crq_pkg::IDX_W'(crq_pkg::QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = i + crq_pkg::IDX_W'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        push_req = fire && (item.command == crq_pkg::CMD_HOST)
                   && (item.usb_kind >= crq_pkg::HK_HELP)
                   && (item.usb_kind <= crq_pkg::HK_PING);
        full     = (count_reg == crq_pkg::CNT_W'(crq_pkg::QUEUE_DEPTH));
        push     = push_req && !full;
        dropped  = push_req && full;

        in_entry.kind = 2'(item.usb_kind - 3'd1);
        in_entry.dest = item.dest_id;
        in_entry.lat  = item.lat_bits;
        in_entry.lng  = item.lng_bits;

        head.avail = (count_reg != '0) || push;
        head.entry = (count_reg == '0) ? in_entry : mem[head_reg];

        head_next  = pop ? next_slot(head_reg) : head_reg;
        tail_next  = push ? next_slot(tail_reg) : tail_reg;
        count_next = crq_pkg::CNT_W'(count_reg + crq_pkg::CNT_W'(push)
                                     - crq_pkg::CNT_W'(pop));
        level      = 3'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= in_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/crq_engine.sv
`default_nettype none

// Current command, retry timer, send counter and sequence number.
module crq_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire crq_pkg::item_t item,
    input  wire crq_pkg::cfg_t  cfg,
    input  wire crq_pkg::head_t head,
    output logic                pop,
    output crq_pkg::tx_t        tx
);

    logic            sending_reg, sending_next;
    logic            due_reg, due_next;
    logic [7:0]      sends_reg, sends_next;
    logic [15:0]     elapsed_reg, elapsed_next;
    logic [7:0]      seq_reg, seq_next;
    crq_pkg::entry_t cur_reg, cur_next;

    logic       rx_clear;
    logic       tick;
    logic       send;
    logic [7:0] sends_inc;
    logic [7:0] seq_inc;

    always_comb
    begin
        rx_clear = fire && (item.command == crq_pkg::CMD_RX) && item.rx_pong;
        tick     = fire && (item.command == crq_pkg::CMD_TICK);

        // A pong acknowledge retires the current command first.
        sending_next = sending_reg && !rx_clear;
        due_next     = due_reg && !rx_clear;
        sends_next   = rx_clear ? 8'd0 : sends_reg;
        seq_next     = seq_reg;
        cur_next     = cur_reg;

        elapsed_next = elapsed_reg;
        if (tick && (elapsed_reg != crq_pkg::ELAPSED_MAX))
        begin
            elapsed_next = elapsed_reg + 16'd1;
        end

        // Take the head when nothing is being repeated.
        pop = fire && !sending_next && head.avail;
        if (pop)
        begin
            cur_next     = head.entry;
            sending_next = 1'b1;
            due_next     = 1'b1;
            sends_next   = 8'd0;
        end

        send      = tick && sending_next
                    && (due_next || (elapsed_next >= cfg.retry_interval));
        sends_inc = (sends_next == crq_pkg::SENDS_MAX) ? sends_next : sends_next + 8'd1;
        seq_inc   = seq_reg + 8'd1;

        if (send)
        begin
            due_next     = 1'b0;
            elapsed_next = 16'd0;
            seq_next     = (seq_inc >= crq_pkg::SEQ_LIMIT) ? 8'd1 : seq_inc;
            if (sends_inc >= cfg.max_sends)
            begin
                sending_next = 1'b0;
                sends_next   = 8'd0;
            end
            else
            begin
                sends_next = sends_inc;
            end
        end

        tx = '0;
        if (send)
        begin
            tx.tx_valid    = 1'b1;
            tx.tx_mesh     = cfg.mesh_id;
            tx.tx_source   = cfg.device_id;
            tx.tx_dest     = cur_next.dest;
            tx.tx_hops     = cfg.hop_limit;
            tx.tx_kind     = cur_next.kind;
            tx.tx_sequence = seq_next;
            tx.tx_lat      = cur_next.lat;
            tx.tx_lng      = cur_next.lng;
        end
        tx.busy_res = sending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg <= 1'b0;
            due_reg     <= 1'b0;
            sends_reg   <= 8'd0;
            elapsed_reg <= 16'd0;
            seq_reg     <= 8'd0;
            cur_reg     <= '0;
        end
        else
        begin
            sending_reg <= sending_next;
            due_reg     <= due_next;
            sends_reg   <= sends_next;
            elapsed_reg <= elapsed_next;
            seq_reg     <= seq_next;
            cur_reg     <= cur_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/command_retransmit_queue.sv
// Channel   Role    Transfer contents
// in_ch     sink    command, usb_kind, dest_id, lat_bits, lng_bits, rx_pong
// out_ch    source  tx_* frame fields, busy_res, queue_level, dropped
// cfg       sink    index (register number), data (write value)
//
// Each input transfer yields one output transfer, registered first in the input
// register and then in the result register. The queue update, dequeue and
// send decision settle in one pass into the result register, so one item per
// cycle is sustained while out_ch.ready stays high. Reset (rst_n low, asynchronous)
// empties the queue and loads the register reset values. A stalled output holds both
// registers, and in_ch.ready drops once both are occupied while out_ch.ready is low.
`default_nettype none

module command_retransmit_queue (
    input  wire logic  clk,
    input  wire logic  rst_n,
    crq_in_if.sink     in_ch,
    crq_out_if.source  out_ch,
    crq_cfg_if.sink    cfg
);

    // Input register stage.
    logic            a_valid_reg, a_valid_next;
    crq_pkg::item_t  a_item_reg;

    // Result register stage.
    logic             b_valid_reg, b_valid_next;
    crq_pkg::result_t b_res_reg;

    // Configuration registers.
    crq_pkg::cfg_t cfg_reg, cfg_next;

    logic             b_free;
    logic             fire;
    logic             in_xfer;
    crq_pkg::item_t   in_item;
    crq_pkg::head_t   head;
    logic             pop;
    logic [2:0]       level;
    logic             dropped;
    crq_pkg::tx_t     tx;
    crq_pkg::result_t result;

    // The result register is free when empty or when its transfer completes
    // this cycle; the item in the input register is processed exactly then.
    assign b_free      = !b_valid_reg || out_ch.ready;
    assign fire        = a_valid_reg && b_free;
    assign in_ch.ready = !a_valid_reg || b_free;
    assign in_xfer     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_item.command  = in_ch.command;
        in_item.usb_kind = in_ch.usb_kind;
        in_item.dest_id  = in_ch.dest_id;
        in_item.lat_bits = in_ch.lat_bits;
        in_item.lng_bits = in_ch.lng_bits;
        in_item.rx_pong  = in_ch.rx_pong;

        a_valid_next = in_xfer || (a_valid_reg && !fire);
        b_valid_next = fire || (b_valid_reg && !out_ch.ready);
    end

    crq_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (a_item_reg),
        .pop     (pop),
        .head    (head),
        .level   (level),
        .dropped (dropped)
    );

    crq_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (a_item_reg),
        .cfg   (cfg_reg),
        .head  (head),
        .pop   (pop),
        .tx    (tx)
    );

    always_comb
    begin
        result.tx          = tx;
        result.queue_level = level;
        result.dropped     = dropped;
    end

    // Configuration writes are always taken; unknown indexes are ignored.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                crq_pkg::CFG_RETRY:     cfg_next.retry_interval = cfg.data;
                crq_pkg::CFG_MAX_SENDS: cfg_next.max_sends      = cfg.data[7:0];
                crq_pkg::CFG_MESH:      cfg_next.mesh_id        = cfg.data[7:0];
                crq_pkg::CFG_DEVICE:    cfg_next.device_id      = cfg.data[7:0];
                crq_pkg::CFG_HOPS:      cfg_next.hop_limit      = cfg.data[7:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg            <= 1'b0;
            b_valid_reg            <= 1'b0;
            cfg_reg.retry_interval <= crq_pkg::RETRY_RESET;
            cfg_reg.max_sends      <= crq_pkg::MAX_SENDS_RESET;
            cfg_reg.mesh_id        <= 8'd0;
            cfg_reg.device_id      <= 8'd0;
            cfg_reg.hop_limit      <= crq_pkg::HOPS_RESET;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            cfg_reg     <= cfg_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            a_item_reg <= in_item;
        end
        if (fire)
        begin
            b_res_reg <= result;
        end
    end

    assign out_ch.valid       = b_valid_reg;
    assign out_ch.tx_valid    = b_res_reg.tx.tx_valid;
    assign out_ch.tx_mesh     = b_res_reg.tx.tx_mesh;
    assign out_ch.tx_source   = b_res_reg.tx.tx_source;
    assign out_ch.tx_dest     = b_res_reg.tx.tx_dest;
    assign out_ch.tx_hops     = b_res_reg.tx.tx_hops;
    assign out_ch.tx_kind     = b_res_reg.tx.tx_kind;
    assign out_ch.tx_sequence = b_res_reg.tx.tx_sequence;
    assign out_ch.tx_lat      = b_res_reg.tx.tx_lat;
    assign out_ch.tx_lng      = b_res_reg.tx.tx_lng;
    assign out_ch.busy_res    = b_res_reg.tx.busy_res;
    assign out_ch.queue_level = b_res_reg.queue_level;
    assign out_ch.dropped     = b_res_reg.dropped;

`ifndef SYNTHESIS
    // A sent frame always carries a sequence number in the range 1 to 253.
    a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_res_reg.tx.tx_valid) |->
        ((b_res_reg.tx.tx_sequence != 8'd0)
         && (b_res_reg.tx.tx_sequence < crq_pkg::SEQ_LIMIT)))
        else $error("sent frame with sequence number out of range");

    // An item waiting behind a stalled result is neither lost nor altered.
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !b_free) |=> (a_valid_reg && $stable(a_item_reg)))
        else $error("input register changed while the result stage was stalled");

    // A new result only appears after an item was processed.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(b_valid_reg) |-> $past(fire))
        else $error("result register filled without a processed item");
`endif

endmodule

`default_nettype wire
